// ----- rtl/mvdre_pkg.sv -----
// ----------------------------------------------------------------------------
// mvdre_pkg
// Shared constants for the motion vector difference rate estimator.
// ----------------------------------------------------------------------------
package mvdre_pkg;

    // Result field width and its saturation limit.
    localparam int unsigned COST_OUT_W = 27;
    localparam logic [COST_OUT_W-1:0] COST_OUT_MAX = {COST_OUT_W{1'b1}};

    // One whole bit in Q15.
    localparam int unsigned Q15_SHIFT = 15;

    // Configuration register file.
    localparam int unsigned NUM_COST_REGS = 6;
    localparam int unsigned CFG_IDX_W     = 3;
    localparam int unsigned NUM_ENTRIES   = 2 * NUM_COST_REGS;
    localparam int unsigned ENTRY_IDX_W   = 4;

    // Base indices of the context groups in the bin cost table.
    localparam logic [ENTRY_IDX_W-1:0] ENT_X_NZ       = 4'd0;
    localparam logic [ENTRY_IDX_W-1:0] ENT_Y_NZ_XZERO = 4'd2;
    localparam logic [ENTRY_IDX_W-1:0] ENT_Y_NZ_XNZ   = 4'd4;
    localparam logic [ENTRY_IDX_W-1:0] ENT_X_GT1      = 4'd6;
    localparam logic [ENTRY_IDX_W-1:0] ENT_Y_GT1_XLE1 = 4'd8;
    localparam logic [ENTRY_IDX_W-1:0] ENT_Y_GT1_XGT1 = 4'd10;

    // Bypass bit count of one component: sign plus Golomb length.
    localparam int unsigned BYP_W     = 6;
    localparam int unsigned BYP_SUM_W = BYP_W + 1;

endpackage

// ----- rtl/mvdre_if.sv -----
// ----------------------------------------------------------------------------
// mvdre_in_if / mvdre_out_if
// Valid/ready channels carrying motion vector difference requests and costs.
// ----------------------------------------------------------------------------
interface mvdre_in_if #(
    parameter int unsigned DIFF_WIDTH = 16
);
    logic                         valid;
    logic                         ready;
    logic signed [DIFF_WIDTH-1:0] diff_x;
    logic signed [DIFF_WIDTH-1:0] diff_y;

    modport source (output valid, output diff_x, output diff_y, input ready);
    modport sink   (input valid, input diff_x, input diff_y, output ready);
endinterface

interface mvdre_out_if;
    logic        valid;
    logic        ready;
    logic [26:0] cost_q15;

    modport source (output valid, output cost_q15, input ready);
    modport sink   (input valid, input cost_q15, output ready);
endinterface

// ----- rtl/mvd_rate_estimator_top.sv -----
// ----------------------------------------------------------------------------
// mvd_rate_estimator_top
// Estimated CABAC coding cost of a motion vector difference pair, in Q15 bits.
// ----------------------------------------------------------------------------
// Usage
//   Requests arrive on i_mvd, a valid/ready channel carrying the signed pair
//   diff_x and diff_y. Each request produces exactly one result on o_cost,
//   carrying cost_q15, the estimated bits in unsigned Q15 (32768 = one bit).
//   The twelve context bin costs are written through the plain write port
//   (i_cfg_we, i_cfg_idx, i_cfg_data); register k holds table entries 2k and
//   2k+1 in its low and high halves. Write only while no request is in flight.
//   Each request passes through one input register and one result register,
//   with the whole cost evaluation (magnitudes, leading-one search, table
//   selection, four-way add and saturation) between them. Throughput is one
//   request per cycle while o_cost.ready stays high.
//   When the receiver stalls, the result register holds its value and the
//   input register still takes one more request; with both full, i_mvd.ready
//   drops until o_cost.ready returns. Ready depends combinationally on
//   o_cost.ready.
//   A synchronous low on i_rst_n empties both pipeline stages and clears all
//   cost registers to zero.
// ----------------------------------------------------------------------------
module mvd_rate_estimator_top #(
    parameter int unsigned COST_WIDTH = 24,
    parameter int unsigned DIFF_WIDTH = 16
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    mvdre_in_if.sink                              i_mvd,
    mvdre_out_if.source                           o_cost,
    input  logic                                  i_cfg_we,
    input  logic [mvdre_pkg::CFG_IDX_W-1:0]       i_cfg_idx,
    input  logic [2*COST_WIDTH-1:0]               i_cfg_data
);
    import mvdre_pkg::*;

    logic [COST_WIDTH-1:0]        entry [NUM_ENTRIES];
    logic signed [DIFF_WIDTH-1:0] r_dx, r_dy;
    logic [COST_OUT_W-1:0]        n_cost, r_cost;
    logic                         s1_load, s1_valid, s2_load, out_valid;

    // Cost table held in configuration registers.
    mvdre_cfg_regs #(
        .COST_WIDTH (COST_WIDTH)
    ) u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_entry    (entry)
    );

    // Handshake and stage valid bits.
    mvdre_stage_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_mvd.valid),
        .o_in_ready  (i_mvd.ready),
        .o_s1_load   (s1_load),
        .o_s1_valid  (s1_valid),
        .o_s2_load   (s2_load),
        .o_out_valid (out_valid),
        .i_out_ready (o_cost.ready)
    );

    // The input register captures the pair on acceptance; it needs no reset
    // because its valid bit lives in the stage controller.
    always_ff @(posedge i_clk) begin
        if (s1_load) begin
            r_dx <= i_mvd.diff_x;
            r_dy <= i_mvd.diff_y;
        end
    end

    // The whole evaluation sits between the input and the result register.
    mvdre_cost_core #(
        .COST_WIDTH (COST_WIDTH),
        .DIFF_WIDTH (DIFF_WIDTH)
    ) u_core (
        .i_diff_x   (r_dx),
        .i_diff_y   (r_dy),
        .i_entry    (entry),
        .o_cost_q15 (n_cost)
    );

    always_ff @(posedge i_clk) begin
        if (s2_load) begin
            r_cost <= n_cost;
        end
    end

    assign o_cost.valid    = out_valid;
    assign o_cost.cost_q15 = r_cost;

    a_result_from_s1: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s2_load |-> s1_valid)
        else $error("result register loaded without a request in the input register");

    a_result_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !s2_load |=> $stable(r_cost))
        else $error("result register changed without a load");

    a_input_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !s1_load |=> $stable(r_dx) && $stable(r_dy))
        else $error("input register changed without an accepted request");

endmodule

// ----- rtl/mvdre_cfg_regs.sv -----
// ----------------------------------------------------------------------------
// mvdre_cfg_regs
// Six bin cost pair registers, presented as a twelve-entry cost table.
// ----------------------------------------------------------------------------
module mvdre_cfg_regs #(
    parameter int unsigned COST_WIDTH = 24
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_cfg_we,
    input  logic [mvdre_pkg::CFG_IDX_W-1:0]       i_cfg_idx,
    input  logic [2*COST_WIDTH-1:0]               i_cfg_data,
    output logic [COST_WIDTH-1:0]                 o_entry [mvdre_pkg::NUM_ENTRIES]
);
    import mvdre_pkg::*;

    logic [2*COST_WIDTH-1:0] r_pair [NUM_COST_REGS];

    // Writes to an index beyond the last register are dropped.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < NUM_COST_REGS; k++) begin
                r_pair[k] <= '0;
            end
        end else if (i_cfg_we) begin
            for (int k = 0; k < NUM_COST_REGS; k++) begin
                if (i_cfg_idx == CFG_IDX_W'(k)) begin
                    r_pair[k] <= i_cfg_data;
                end
            end
        end
    end

    always_comb begin
        for (int k = 0; k < NUM_COST_REGS; k++) begin
            o_entry[2*k]   = r_pair[k][COST_WIDTH-1:0];
            o_entry[2*k+1] = r_pair[k][2*COST_WIDTH-1:COST_WIDTH];
        end
    end

endmodule

// ----- rtl/mvdre_cost_core.sv -----
// ----------------------------------------------------------------------------
// mvdre_cost_core
// Combinational cost of one difference pair: table bins plus bypass bits.
// ----------------------------------------------------------------------------
module mvdre_cost_core #(
    parameter int unsigned COST_WIDTH = 24,
    parameter int unsigned DIFF_WIDTH = 16
) (
    input  logic signed [DIFF_WIDTH-1:0]          i_diff_x,
    input  logic signed [DIFF_WIDTH-1:0]          i_diff_y,
    input  logic [COST_WIDTH-1:0]                 i_entry [mvdre_pkg::NUM_ENTRIES],
    output logic [mvdre_pkg::COST_OUT_W-1:0]      o_cost_q15
);
    import mvdre_pkg::*;

    localparam int unsigned BASE_W = (COST_WIDTH > BYP_SUM_W + Q15_SHIFT) ?
                                     COST_WIDTH : (BYP_SUM_W + Q15_SHIFT);
    // Never narrower than the result, so the saturation compare and the
    // final part-select stay in range for narrow table entries.
    localparam int unsigned SUM_W  = (BASE_W + 3 > COST_OUT_W) ? (BASE_W + 3) : COST_OUT_W;

    logic [DIFF_WIDTH-1:0] mag_x, mag_y;
    logic                  xnz, ynz, xgt1, ygt1;
    logic [BYP_W-1:0]      msb_x, msb_y;
    logic [BYP_W-1:0]      byp_x, byp_y;
    logic [BYP_SUM_W-1:0]  byp_sum;
    logic [ENTRY_IDX_W-1:0] idx0, idx1, idx2, idx3;
    logic [COST_WIDTH-1:0] e0, e1, e2, e3;
    logic [SUM_W-1:0]      sum;

    // The magnitude of the most negative value is exactly representable
    // as an unsigned number of the same width.
    assign mag_x = i_diff_x[DIFF_WIDTH-1] ? (~i_diff_x + 1'b1) : i_diff_x;
    assign mag_y = i_diff_y[DIFF_WIDTH-1] ? (~i_diff_y + 1'b1) : i_diff_y;

    assign xnz  = |mag_x;
    assign ynz  = |mag_y;
    assign xgt1 = |mag_x[DIFF_WIDTH-1:1];
    assign ygt1 = |mag_y[DIFF_WIDTH-1:1];

    // Leading-one position of each magnitude.
    always_comb begin
        msb_x = '0;
        msb_y = '0;
        for (int b = 0; b < DIFF_WIDTH; b++) begin
            if (mag_x[b]) msb_x = BYP_W'(b);
            if (mag_y[b]) msb_y = BYP_W'(b);
        end
    end

    // The order-1 Golomb code of (m - 2) is 2*floor(log2(m)) bits long.
    assign byp_x = !xnz ? '0 : (xgt1 ? (BYP_W'({msb_x, 1'b0}) + 1'b1) : BYP_W'(1));
    assign byp_y = !ynz ? '0 : (ygt1 ? (BYP_W'({msb_y, 1'b0}) + 1'b1) : BYP_W'(1));
    assign byp_sum = BYP_SUM_W'(byp_x) + BYP_SUM_W'(byp_y);

    assign idx0 = ENT_X_NZ + ENTRY_IDX_W'(xnz);
    assign idx1 = (xnz ? ENT_Y_NZ_XNZ : ENT_Y_NZ_XZERO) + ENTRY_IDX_W'(ynz);
    assign idx2 = ENT_X_GT1 + ENTRY_IDX_W'(xgt1);
    assign idx3 = (xgt1 ? ENT_Y_GT1_XGT1 : ENT_Y_GT1_XLE1) + ENTRY_IDX_W'(ygt1);

    assign e0 = i_entry[idx0];
    assign e1 = i_entry[idx1];
    assign e2 = xnz ? i_entry[idx2] : '0;
    assign e3 = ynz ? i_entry[idx3] : '0;

    assign sum = SUM_W'(e0) + SUM_W'(e1) + SUM_W'(e2) + SUM_W'(e3)
               + (SUM_W'(byp_sum) << Q15_SHIFT);

    assign o_cost_q15 = (sum > SUM_W'(COST_OUT_MAX)) ? COST_OUT_MAX
                                                     : sum[COST_OUT_W-1:0];

endmodule

// ----- rtl/mvdre_top_placeholder.sv -----
// ----------------------------------------------------------------------------
// mvdre_stage_ctrl
// Two-stage valid/ready pipeline control: input register and result register.
// ----------------------------------------------------------------------------
module mvdre_stage_ctrl (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_ready,
    output logic o_s1_load,
    output logic o_s1_valid,
    output logic o_s2_load,
    output logic o_out_valid,
    input  logic i_out_ready
);
    logic r_s1_valid, r_s2_valid;
    logic s1_adv;

    // The result register frees up when it is empty or being taken.
    assign s1_adv     = !r_s2_valid || i_out_ready;
    assign o_in_ready = !r_s1_valid || s1_adv;
    assign o_s1_load  = i_in_valid && o_in_ready;
    assign o_s2_load  = r_s1_valid && s1_adv;
    assign o_s1_valid = r_s1_valid;
    assign o_out_valid = r_s2_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_s2_valid <= 1'b0;
        end else begin
            if (o_in_ready) begin
                r_s1_valid <= i_in_valid;
            end
            if (s1_adv) begin
                r_s2_valid <= r_s1_valid;
            end
        end
    end

    a_accept_fills_s1: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> r_s1_valid)
        else $error("accepted request did not reach the input register");

    a_s1_moves_to_s2: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s1_valid && s1_adv |=> r_s2_valid)
        else $error("input register advanced without filling the result register");

    a_s1_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s1_valid && !s1_adv |=> r_s1_valid)
        else $error("stalled input register lost its request");

    a_ready_when_out_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_s2_valid |-> o_in_ready)
        else $error("input not ready although the result register is empty");

endmodule

// ----- test/mvdre_checker.sv -----
// ----------------------------------------------------------------------------
// mvdre_checker
// Watches the request and cost channels and the register write port, works
// out the cost of every accepted request and compares it with the result.
// ----------------------------------------------------------------------------
module mvdre_checker #(
    parameter int unsigned COST_WIDTH = 24,
    parameter int unsigned DIFF_WIDTH = 16
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    mvdre_in_if                                 i_mvd,
    mvdre_out_if                                i_cost,
    input  logic                                i_cfg_we,
    input  logic [mvdre_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [2*COST_WIDTH-1:0]             i_cfg_data,
    output int                                  o_fail_count,
    output int                                  o_checked,
    output int                                  o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    import mvdre_pkg::*;

    localparam longint unsigned ONE_BIT = 64'd1 << Q15_SHIFT;

    typedef struct {
        logic signed [DIFF_WIDTH-1:0] diff_x;
        logic signed [DIFF_WIDTH-1:0] diff_y;
        logic [COST_OUT_W-1:0]        cost_q15;
    } t_cost_expect;

    logic [COST_WIDTH-1:0] bin_cost [NUM_ENTRIES];
    t_cost_expect          costs_in_flight [$];

    function automatic logic [DIFF_WIDTH:0] abs_diff(logic signed [DIFF_WIDTH-1:0] d);
        logic signed [DIFF_WIDTH:0] wide;
        wide = d;
        return (wide < 0) ? -wide : wide;
    endfunction

    // Length of the order-1 exponential-Golomb code of sym.
    function automatic int unsigned golomb1_len(int unsigned sym);
        int unsigned k;
        int unsigned prefix;
        k      = 1;
        prefix = 0;
        while (k < 31 && sym >= (32'd1 << k)) begin
            prefix++;
            sym -= (32'd1 << k);
            k++;
        end
        return prefix + 1 + k;
    endfunction

    function automatic logic [COST_OUT_W-1:0] predict_cost_q15(
        logic signed [DIFF_WIDTH-1:0] dx,
        logic signed [DIFF_WIDTH-1:0] dy
    );
        logic [DIFF_WIDTH:0] ax;
        logic [DIFF_WIDTH:0] ay;
        logic                xnz;
        logic                ynz;
        logic                xgt1;
        logic                ygt1;
        longint unsigned     sum;
        ax   = abs_diff(dx);
        ay   = abs_diff(dy);
        xnz  = (ax != 0);
        ynz  = (ay != 0);
        xgt1 = (ax > 1);
        ygt1 = (ay > 1);

        sum = bin_cost[ENT_X_NZ + xnz];
        sum += bin_cost[(xnz ? ENT_Y_NZ_XNZ : ENT_Y_NZ_XZERO) + ynz];
        if (xnz) begin
            sum += bin_cost[ENT_X_GT1 + xgt1];
        end
        if (ynz) begin
            sum += bin_cost[(xgt1 ? ENT_Y_GT1_XGT1 : ENT_Y_GT1_XLE1) + ygt1];
        end

        // Sign bits and suffix lengths are whole bypass bits.
        if (xnz) begin
            sum += ONE_BIT;
            if (xgt1) begin
                sum += longint'(golomb1_len(int'(ax) - 2)) * ONE_BIT;
            end
        end
        if (ynz) begin
            sum += ONE_BIT;
            if (ygt1) begin
                sum += longint'(golomb1_len(int'(ay) - 2)) * ONE_BIT;
            end
        end

        if (sum > COST_OUT_MAX) begin
            sum = COST_OUT_MAX;
        end
        return sum[COST_OUT_W-1:0];
    endfunction

    task automatic report_mismatch(input string what);
        $display("[%0t] cost mismatch: %s", $realtime, what);
        o_fail_count++;
    endtask

    always @(posedge i_clk) begin : watch
        t_cost_expect head;
        if (!i_rst_n) begin
            foreach (bin_cost[e]) begin
                bin_cost[e] = '0;
            end
            costs_in_flight.delete();
            o_fail_count = 0;
            o_checked    = 0;
        end else begin
            // Writes to indexes beyond the table are dropped by the block.
            if (i_cfg_we && i_cfg_idx < NUM_COST_REGS) begin
                bin_cost[2*i_cfg_idx]     = i_cfg_data[COST_WIDTH-1:0];
                bin_cost[2*i_cfg_idx + 1] = i_cfg_data[2*COST_WIDTH-1:COST_WIDTH];
            end
            if (i_mvd.valid && i_mvd.ready) begin
                costs_in_flight.push_back('{i_mvd.diff_x, i_mvd.diff_y,
                                            predict_cost_q15(i_mvd.diff_x, i_mvd.diff_y)});
            end
            if (i_cost.valid && i_cost.ready) begin
                if (costs_in_flight.size() == 0) begin
                    report_mismatch($sformatf("cost_q15 %0d arrived with no request outstanding",
                                              i_cost.cost_q15));
                end else begin
                    head = costs_in_flight.pop_front();
                    o_checked++;
                    if (i_cost.cost_q15 !== head.cost_q15) begin
                        report_mismatch($sformatf("request (%0d, %0d): cost_q15 %0d, expected %0d",
                                                  head.diff_x, head.diff_y,
                                                  i_cost.cost_q15, head.cost_q15));
                    end
                end
            end
        end
        o_pending <= costs_in_flight.size();
    end

endmodule

// ----- test/tb.sv -----
// ----------------------------------------------------------------------------
// tb
// Stimulus for the motion vector difference rate estimator: directed corner
// pairs, then random pairs under several cost tables with random idling on
// both channels and one long result stall; the checker does the comparing.
// ----------------------------------------------------------------------------
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import mvdre_pkg::*;

    localparam int unsigned COST_WIDTH      = 24;
    localparam int unsigned DIFF_WIDTH      = 16;
    localparam int unsigned COST_REG_W      = 2 * COST_WIDTH;
    // Every index the write port can address, reserved ones included.
    localparam int unsigned CFG_SLOTS       = 1 << CFG_IDX_W;
    localparam int          DIFF_MIN        = -(1 << (DIFF_WIDTH - 1));
    localparam int          DIFF_MAX        = (1 << (DIFF_WIDTH - 1)) - 1;
    localparam int unsigned RESET_COUNT     = 4;
    localparam int unsigned DIRECTED_COUNT  = 22;
    localparam int unsigned RANDOM_PHASES   = 6;
    localparam int unsigned PER_PHASE       = 170;
    localparam int unsigned HOLD_OFF_CYCLES = 200;
    localparam int unsigned HOLD_OFF_AT     = 40;
    // Two pipeline stages, plus a little margin.
    localparam int unsigned DRAIN_CYCLES    = 4;
    localparam int unsigned WATCHDOG_LIMIT  = 2000;

    typedef logic [COST_REG_W-1:0] t_cost_regs [CFG_SLOTS];
    typedef enum {TBL_ZERO, TBL_MAX, TBL_DISTINCT, TBL_RANDOM} t_table_kind;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_idx;
    logic [COST_REG_W-1:0] cfg_data;

    int   fail_count;
    int   costs_checked;
    int   costs_pending;
    int   requests_sent;
    int   tables_loaded;
    bit   idle_on;
    logic hold_request;

    // A few requests under the all-zero table left by reset.
    int reset_pairs [RESET_COUNT][2] = '{
        '{0, 0}, '{5, -9}, '{DIFF_MIN, DIFF_MAX}, '{1, 0}
    };

    // Zero, one and above-one on each component, the boundaries where the
    // Golomb suffix grows, both extremes and the most negative value.
    int directed_pairs [DIRECTED_COUNT][2] = '{
        '{0, 0}, '{1, 0}, '{-1, 0}, '{0, 1}, '{0, -1}, '{1, 1}, '{-1, -1},
        '{2, 0}, '{0, -2}, '{2, 2}, '{1, 2}, '{2, 1}, '{3, -3}, '{3, 4},
        '{7, 8}, '{DIFF_MAX, -DIFF_MAX}, '{DIFF_MIN, DIFF_MIN}, '{DIFF_MIN, 0},
        '{0, DIFF_MAX}, '{DIFF_MIN, 1}, '{1, DIFF_MIN}, '{-8, 9}
    };

    // Table used by each random phase, and whether its channels idle.
    t_table_kind phase_table [RANDOM_PHASES] = '{
        TBL_MAX, TBL_RANDOM, TBL_ZERO, TBL_RANDOM, TBL_DISTINCT, TBL_RANDOM
    };
    bit phase_idle [RANDOM_PHASES] = '{1'b0, 1'b1, 1'b1, 1'b0, 1'b1, 1'b1};

    mvdre_in_if #(.DIFF_WIDTH(DIFF_WIDTH)) mvd_req ();
    mvdre_out_if                           cost_rsp ();

    mvd_rate_estimator_top #(
        .COST_WIDTH (COST_WIDTH),
        .DIFF_WIDTH (DIFF_WIDTH)
    ) DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_mvd      (mvd_req),
        .o_cost     (cost_rsp),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data)
    );

    // The checker sits beside the block and sees exactly what it sees.
    mvdre_checker #(
        .COST_WIDTH (COST_WIDTH),
        .DIFF_WIDTH (DIFF_WIDTH)
    ) u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_mvd        (mvd_req),
        .i_cost       (cost_rsp),
        .i_cfg_we     (cfg_we),
        .i_cfg_idx    (cfg_idx),
        .i_cfg_data   (cfg_data),
        .o_fail_count (fail_count),
        .o_checked    (costs_checked),
        .o_pending    (costs_pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Builds the contents of all write slots. The two reserved slots always
    // get random data, so that a write which is not ignored corrupts a
    // live register and shows up in the costs.
    function automatic t_cost_regs make_table(t_table_kind kind);
        t_cost_regs            regs;
        logic [COST_WIDTH-1:0] lo;
        logic [COST_WIDTH-1:0] hi;
        for (int i = 0; i < CFG_SLOTS; i++) begin
            case (kind)
                TBL_ZERO: begin
                    regs[i] = '0;
                end
                TBL_MAX: begin
                    regs[i] = '1;
                end
                TBL_DISTINCT: begin
                    // Entry e holds 4**e, so any wrong entry selection
                    // changes the sum in a way that stands out.
                    lo      = COST_WIDTH'(1) << (4 * i);
                    hi      = COST_WIDTH'(1) << (4 * i + 2);
                    regs[i] = {hi, lo};
                end
                default: begin
                    regs[i] = COST_REG_W'({$urandom(), $urandom()});
                end
            endcase
            if (i >= NUM_COST_REGS) begin
                regs[i] = COST_REG_W'({$urandom(), $urandom()});
            end
        end
        return regs;
    endfunction

    // Writes every slot on consecutive edges; the enable stays high across
    // the burst and drops once, after the last slot.
    task automatic load_cost_table(input t_table_kind kind);
        t_cost_regs regs;
        regs = make_table(kind);
        for (int i = 0; i < CFG_SLOTS; i++) begin
            cfg_we   <= 1'b1;
            cfg_idx  <= CFG_IDX_W'(i);
            cfg_data <= regs[i];
            @(posedge i_clk);
        end
        cfg_we <= 1'b0;
        tables_loaded++;
    endtask

    // Presents one request after a random gap and returns at the edge that
    // accepts it. Valid is left high so back-to-back requests need no gap.
    task automatic send_mvd(input int dx, input int dy);
        int gap;
        gap = idle_on ? $urandom_range(0, 4) : 0;
        repeat (gap) begin
            mvd_req.valid <= 1'b0;
            @(posedge i_clk);
        end
        mvd_req.valid  <= 1'b1;
        mvd_req.diff_x <= DIFF_WIDTH'(dx);
        mvd_req.diff_y <= DIFF_WIDTH'(dy);
        @(posedge i_clk);
        while (!mvd_req.ready) begin
            @(posedge i_clk);
        end
        requests_sent++;
    endtask

    // Random difference, weighted towards the values where the cost changes
    // shape: around zero, short vectors, Golomb boundaries and the extremes.
    function automatic int draw_diff();
        int unsigned pick;
        int unsigned mag;
        pick = $urandom_range(0, 99);
        if (pick < 35) begin
            return int'($urandom_range(0, 6)) - 3;
        end else if (pick < 60) begin
            mag = $urandom_range(0, 64);
            return $urandom_range(0, 1) ? -int'(mag) : int'(mag);
        end else if (pick < 85) begin
            return int'($signed(DIFF_WIDTH'($urandom())));
        end else if (pick < 95) begin
            mag = (32'd1 << $urandom_range(1, DIFF_WIDTH - 1)) + $urandom_range(0, 2) - 1;
            if (mag >= -DIFF_MIN) begin
                return DIFF_MIN;
            end
            return $urandom_range(0, 1) ? -int'(mag) : int'(mag);
        end else begin
            case ($urandom_range(0, 2))
                0:       return DIFF_MIN;
                1:       return DIFF_MAX;
                default: return -DIFF_MAX;
            endcase
        end
    endfunction

    // Waits until every accepted request has produced its cost, then lets
    // the pipeline settle. The first edge makes sure the checker has seen
    // the final acceptance before its count is read.
    task automatic wait_for_drain();
        @(posedge i_clk);
        while (costs_pending != 0) begin
            @(posedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // Result side: random stalls per result, and on request one long
    // hold-off during which the block fills up and refuses new requests.
    initial begin : cost_sink
        int stall;
        do begin
            @(posedge i_clk);
        end while (!i_rst_n);
        forever begin
            if (hold_request) begin
                hold_request   <= 1'b0;
                cost_rsp.ready <= 1'b0;
                repeat (HOLD_OFF_CYCLES) @(posedge i_clk);
            end
            stall = idle_on ? $urandom_range(0, 4) : 0;
            if (stall > 0) begin
                cost_rsp.ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            cost_rsp.ready <= 1'b1;
            @(posedge i_clk);
            while (!cost_rsp.valid) begin
                @(posedge i_clk);
            end
        end
    end

    // Ends the run if neither channel nor the write port moves for too long.
    // The longest quiet stretch of a correct run is the deliberate hold-off.
    initial begin : watchdog
        int quiet_cycles;
        quiet_cycles = 0;
        while (quiet_cycles < WATCHDOG_LIMIT) begin
            @(posedge i_clk);
            if (!i_rst_n || cfg_we || (mvd_req.valid && mvd_req.ready) ||
                (cost_rsp.valid && cost_rsp.ready)) begin
                quiet_cycles = 0;
            end else begin
                quiet_cycles++;
            end
        end
        $display("Watchdog: no request or cost moved for %0d cycles", WATCHDOG_LIMIT);
        $display("TEST FAILED");
        $finish;
    end

    initial begin : stimulus
        // Every input is known from time zero.
        i_rst_n        <= 1'b0;
        cfg_we         <= 1'b0;
        cfg_idx        <= '0;
        cfg_data       <= '0;
        mvd_req.valid  <= 1'b0;
        mvd_req.diff_x <= '0;
        mvd_req.diff_y <= '0;
        cost_rsp.ready <= 1'b0;
        hold_request   <= 1'b0;
        idle_on        = 1'b1;
        requests_sent  = 0;
        tables_loaded  = 0;

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed part: first against the cleared table, then against a
        // table whose entries can be told apart.
        for (int i = 0; i < RESET_COUNT; i++) begin
            send_mvd(reset_pairs[i][0], reset_pairs[i][1]);
        end
        mvd_req.valid <= 1'b0;
        wait_for_drain();

        load_cost_table(TBL_DISTINCT);
        for (int i = 0; i < DIRECTED_COUNT; i++) begin
            send_mvd(directed_pairs[i][0], directed_pairs[i][1]);
        end
        mvd_req.valid <= 1'b0;
        wait_for_drain();

        // Random part. Tables are only rewritten once the pipeline is empty.
        // The first phase runs without idling and holds the result side off
        // for a long stretch while requests keep coming.
        for (int p = 0; p < RANDOM_PHASES; p++) begin
            idle_on = phase_idle[p];
            load_cost_table(phase_table[p]);
            for (int n = 0; n < PER_PHASE; n++) begin
                if (p == 0 && n == HOLD_OFF_AT) begin
                    hold_request <= 1'b1;
                end
                send_mvd(draw_diff(), draw_diff());
            end
            mvd_req.valid <= 1'b0;
            wait_for_drain();
        end

        $display("Coverage: %0d requests (%0d directed), %0d costs compared, %0d table loads,",
                 requests_sent, RESET_COUNT + DIRECTED_COUNT, costs_checked, tables_loaded);
        $display("          reserved-index writes, idle and busy phases, one %0d-cycle stall.",
                 HOLD_OFF_CYCLES);
        if (fail_count == 0 && costs_pending == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("%0d mismatches, %0d costs never arrived", fail_count, costs_pending);
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
